>>> hdl/dcs_pkg.sv
`default_nettype none

package dcs_pkg;

    localparam int BLK_W      = 48;
    localparam int CNT_W      = 7;
    localparam int SPT_W      = 6;
    localparam int HDS_W      = 9;
    localparam int CYL_W      = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 9;
    localparam int S_DATA_W   = 56;
    localparam int M_DATA_W   = 120;

    localparam logic [CNT_W-1:0] MAX_BLOCKS   = 7'd64;
    localparam logic [CYL_W-1:0] MAX_CYLINDER = 10'd1023;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SPT    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEADS  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DRIVE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_EXT    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT  = 3'd4;

    // command bytes
    localparam logic [6:0] FN_READ      = 7'd2;
    localparam logic [6:0] FN_WRITE     = 7'd3;
    localparam logic [6:0] FN_EXT_READ  = 7'd66;
    localparam logic [6:0] FN_EXT_WRITE = 7'd67;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_DIV_Q,
        ST_DIV_C,
        ST_EMIT
    } state_t;

    typedef enum logic {
        DIV_BY_SPT,
        DIV_BY_HEADS
    } div_sel_t;

    typedef struct packed {
        logic     load_req;
        logic     div_start;
        div_sel_t div_sel;
        logic     latch_q;
        logic     latch_c;
        logic     advance;
    } cmd_t;

    typedef struct packed {
        logic in_zero;
        logic div_done;
        logic wrap;
        logic final_item;
    } stat_t;

endpackage

`default_nettype wire

>>> hdl/dcs_div.sv
`default_nettype none

// Restoring divider, one quotient bit a cycle, 48 steps.
module dcs_div (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        start,
    input  wire logic [dcs_pkg::BLK_W-1:0]   dividend,
    input  wire logic [dcs_pkg::HDS_W-1:0]   divisor,
    output logic                             done,
    output logic [dcs_pkg::BLK_W-1:0]        quotient,
    output logic [dcs_pkg::HDS_W-1:0]        remainder
);

    logic                       busy_reg, busy_next;
    logic                       done_reg, done_next;
    logic [5:0]                 cnt_reg, cnt_next;
    logic [dcs_pkg::BLK_W-1:0]  quo_reg, quo_next;
    logic [dcs_pkg::HDS_W-1:0]  rem_reg, rem_next;
    logic [dcs_pkg::HDS_W-1:0]  div_reg, div_next;
    logic [dcs_pkg::HDS_W:0]    partial;
    logic [dcs_pkg::HDS_W+1:0]  diff;
    logic                       ge;

    assign partial = {rem_reg, quo_reg[dcs_pkg::BLK_W-1]};
    assign diff    = {1'b0, partial} - {2'b00, div_reg};
    assign ge      = ~diff[dcs_pkg::HDS_W+1];

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = dividend;
            rem_next  = '0;
            div_next  = divisor;
        end else if (busy_reg) begin
            quo_next = {quo_reg[dcs_pkg::BLK_W-2:0], ge};
            rem_next = ge ? diff[dcs_pkg::HDS_W-1:0] : partial[dcs_pkg::HDS_W-1:0];
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'(dcs_pkg::BLK_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

>>> hdl/dcs_datapath.sv
`default_nettype none

module dcs_datapath (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire dcs_pkg::cmd_t                    cmd,
    output dcs_pkg::stat_t                        stat,
    input  wire logic [dcs_pkg::S_DATA_W-1:0]     s_data,
    input  wire logic                             s_user,
    input  wire logic                             cfg_we,
    input  wire logic [dcs_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [dcs_pkg::CFG_DATA_W-1:0]   cfg_data,
    output logic [dcs_pkg::M_DATA_W-1:0]          m_data,
    output logic                                  m_user,
    output logic                                  m_last
);

    // configuration
    logic [dcs_pkg::SPT_W-1:0]  spt_reg;
    logic [dcs_pkg::HDS_W-1:0]  heads_reg;
    logic [7:0]                 drive_reg;
    logic                       ext_reg;
    logic [4:0]                 limit_reg;

    // request and position state
    logic [dcs_pkg::BLK_W-1:0]  blk_reg, blk_next;
    logic [dcs_pkg::CNT_W-1:0]  resid_reg, resid_next;
    logic                       wr_reg, wr_next;
    logic [dcs_pkg::SPT_W-1:0]  sec_off_reg, sec_off_next;
    logic [dcs_pkg::HDS_W-1:0]  hd_reg, hd_next;
    logic [dcs_pkg::CYL_W-1:0]  cyl_reg, cyl_next;
    logic                       big_reg, big_next;

    logic [dcs_pkg::SPT_W-1:0]  spt_eff;
    logic [dcs_pkg::HDS_W-1:0]  hds_eff;
    logic [dcs_pkg::BLK_W-1:0]  div_dividend;
    logic [dcs_pkg::HDS_W-1:0]  div_divisor;
    logic                       div_done;
    logic [dcs_pkg::BLK_W-1:0]  div_quo;
    logic [dcs_pkg::HDS_W-1:0]  div_rem;

    logic [dcs_pkg::CNT_W-1:0]  in_cnt;
    logic [dcs_pkg::SPT_W-1:0]  avail;
    logic [dcs_pkg::CNT_W-1:0]  x_track;
    logic [dcs_pkg::CNT_W-1:0]  x_cnt;
    logic [dcs_pkg::BLK_W:0]    blk_sum;
    logic [dcs_pkg::CNT_W-1:0]  sec_sum;
    logic [dcs_pkg::HDS_W:0]    hd_inc;
    logic                       is_last;
    logic                       range_err;

    logic [6:0]                 o_fn;
    logic [dcs_pkg::CYL_W-1:0]  o_cyl;
    logic [7:0]                 o_head;
    logic [dcs_pkg::SPT_W-1:0]  o_sec;
    logic [15:0]                o_cx;
    logic [15:0]                o_dx;

    assign spt_eff = (spt_reg == '0) ? dcs_pkg::SPT_W'(1) : spt_reg;
    assign hds_eff = (heads_reg == '0) ? dcs_pkg::HDS_W'(1) : heads_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            spt_reg   <= 6'd63;
            heads_reg <= 9'd16;
            drive_reg <= 8'd128;
            ext_reg   <= 1'b0;
            limit_reg <= 5'd0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                dcs_pkg::REG_SPT:   spt_reg   <= cfg_data[dcs_pkg::SPT_W-1:0];
                dcs_pkg::REG_HEADS: heads_reg <= cfg_data;
                dcs_pkg::REG_DRIVE: drive_reg <= cfg_data[7:0];
                dcs_pkg::REG_EXT:   ext_reg   <= cfg_data[0];
                dcs_pkg::REG_LIMIT: limit_reg <= cfg_data[4:0];
                default: ;
            endcase
        end
    end

    // shared divider: block / spt first, then that quotient / heads
    assign div_dividend = (cmd.div_sel == dcs_pkg::DIV_BY_SPT) ? blk_reg : div_quo;
    assign div_divisor  = (cmd.div_sel == dcs_pkg::DIV_BY_SPT)
                          ? {3'b000, spt_eff} : hds_eff;

    dcs_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (cmd.div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // chunk size: up to the end of the track, the residue and the limit
    assign in_cnt  = s_data[dcs_pkg::BLK_W +: dcs_pkg::CNT_W];
    assign avail   = spt_eff - sec_off_reg;
    assign x_track = ({1'b0, avail} < resid_reg) ? {1'b0, avail} : resid_reg;
    assign x_cnt   = (limit_reg != '0 && x_track > {2'b00, limit_reg})
                     ? {2'b00, limit_reg} : x_track;
    assign is_last = (x_cnt == resid_reg);
    assign range_err = ~ext_reg & big_reg;

    assign blk_sum = {1'b0, blk_reg} + {{(dcs_pkg::BLK_W + 1 - dcs_pkg::CNT_W){1'b0}}, x_cnt};
    assign sec_sum = {1'b0, sec_off_reg} + x_cnt;
    assign hd_inc  = {1'b0, hd_reg} + 10'd1;

    always_comb begin
        blk_next     = blk_reg;
        resid_next   = resid_reg;
        wr_next      = wr_reg;
        sec_off_next = sec_off_reg;
        hd_next      = hd_reg;
        cyl_next     = cyl_reg;
        big_next     = big_reg;
        if (cmd.load_req) begin
            blk_next   = s_data[dcs_pkg::BLK_W-1:0];
            resid_next = (in_cnt > dcs_pkg::MAX_BLOCKS) ? dcs_pkg::MAX_BLOCKS : in_cnt;
            wr_next    = s_user;
        end
        if (cmd.latch_q) begin
            sec_off_next = div_rem[dcs_pkg::SPT_W-1:0];
        end
        if (cmd.latch_c) begin
            hd_next  = div_rem;
            cyl_next = div_quo[dcs_pkg::CYL_W-1:0];
            big_next = |div_quo[dcs_pkg::BLK_W-1:dcs_pkg::CYL_W];
        end
        if (cmd.advance) begin
            blk_next   = blk_sum[dcs_pkg::BLK_W-1:0];
            resid_next = resid_reg - x_cnt;
            // step along track, head and cylinder; a wrapped address is re-split
            if (sec_sum == {1'b0, spt_eff}) begin
                sec_off_next = '0;
                if (hd_inc == {1'b0, hds_eff}) begin
                    hd_next = '0;
                    if (cyl_reg == dcs_pkg::MAX_CYLINDER) begin
                        big_next = 1'b1;
                    end else begin
                        cyl_next = cyl_reg + 10'd1;
                    end
                end else begin
                    hd_next = hd_inc[dcs_pkg::HDS_W-1:0];
                end
            end else begin
                sec_off_next = sec_sum[dcs_pkg::SPT_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        blk_reg     <= blk_next;
        resid_reg   <= resid_next;
        wr_reg      <= wr_next;
        sec_off_reg <= sec_off_next;
        hd_reg      <= hd_next;
        cyl_reg     <= cyl_next;
        big_reg     <= big_next;
    end

    assign stat.in_zero    = (in_cnt == '0);
    assign stat.div_done   = div_done;
    assign stat.wrap       = blk_sum[dcs_pkg::BLK_W];
    assign stat.final_item = is_last | range_err;

    // result item
    always_comb begin
        if (ext_reg) begin
            o_fn   = wr_reg ? dcs_pkg::FN_EXT_WRITE : dcs_pkg::FN_EXT_READ;
            o_cyl  = '0;
            o_head = '0;
            o_sec  = '0;
            o_cx   = '0;
            o_dx   = {8'h00, drive_reg};
        end else begin
            o_fn   = wr_reg ? dcs_pkg::FN_WRITE : dcs_pkg::FN_READ;
            o_head = hd_reg[7:0];
            o_sec  = sec_off_reg + 6'd1;
            if (big_reg) begin
                o_cyl = '0;
                o_cx  = '0;
                o_dx  = '0;
            end else begin
                o_cyl = cyl_reg;
                o_cx  = {cyl_reg[7:0], cyl_reg[9:8], o_sec};
                o_dx  = {hd_reg[7:0], drive_reg};
            end
        end
    end

    assign m_data = {3'b000, o_dx, o_cx, o_sec, o_head, o_cyl,
                     x_cnt[dcs_pkg::SPT_W-1:0], blk_reg, o_fn};
    assign m_user = range_err;
    assign m_last = is_last | range_err;

endmodule

`default_nettype wire

>>> hdl/dcs_ctrl.sv
`default_nettype none

module dcs_ctrl (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_valid,
    output logic                s_ready,
    output logic                m_valid,
    input  wire logic           m_ready,
    input  wire dcs_pkg::stat_t stat,
    output dcs_pkg::cmd_t       cmd
);

    dcs_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= dcs_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        cmd.load_req  = 1'b0;
        cmd.div_start = 1'b0;
        cmd.div_sel   = dcs_pkg::DIV_BY_SPT;
        cmd.latch_q   = 1'b0;
        cmd.latch_c   = 1'b0;
        cmd.advance   = 1'b0;
        s_ready       = 1'b0;
        m_valid       = 1'b0;
        unique case (state_reg)
            dcs_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_req = 1'b1;
                    // an empty request gives no items
                    if (!stat.in_zero) begin
                        state_next = dcs_pkg::ST_LOAD;
                    end
                end
            end
            dcs_pkg::ST_LOAD: begin
                cmd.div_start = 1'b1;
                state_next    = dcs_pkg::ST_DIV_Q;
            end
            dcs_pkg::ST_DIV_Q: begin
                if (stat.div_done) begin
                    cmd.latch_q   = 1'b1;
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = dcs_pkg::DIV_BY_HEADS;
                    state_next    = dcs_pkg::ST_DIV_C;
                end
            end
            dcs_pkg::ST_DIV_C: begin
                cmd.div_sel = dcs_pkg::DIV_BY_HEADS;
                if (stat.div_done) begin
                    cmd.latch_c = 1'b1;
                    state_next  = dcs_pkg::ST_EMIT;
                end
            end
            dcs_pkg::ST_EMIT: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    if (stat.final_item) begin
                        state_next = dcs_pkg::ST_IDLE;
                    end else begin
                        cmd.advance = 1'b1;
                        if (stat.wrap) begin
                            state_next = dcs_pkg::ST_LOAD;
                        end
                    end
                end
            end
            default: state_next = dcs_pkg::ST_IDLE;
        endcase
    end

endmodule

`default_nettype wire

>>> hdl/disk_request_chs_splitter.sv
`default_nettype none

// Channel   Direction  Handshake             Payload
// s_axis    in         s_axis_tvalid/tready  request: type, start block, block count
// m_axis    out        m_axis_tvalid/tready  one disk command per chunk
// cfg       in         cfg_valid/cfg_ready   register index, write data
//
// First item of a request: two 48-step divisions on the shared one-bit-a-cycle
// divider (block / sectors, then that / heads).
// Further items of the same request: one cycle each while m_axis_tready is high;
// a block address wrapping past 48 bits re-runs both divisions.
// A new request is taken only once the last item of the previous one has left.
// Reset (aresetn low, synchronous) returns to idle and loads the register defaults.
module disk_request_chs_splitter (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // [47:0] start_block, [54:48] block_count, [55] zero
    input  wire logic [dcs_pkg::S_DATA_W-1:0]      s_axis_tdata,
    // [0] req_type
    input  wire logic                              s_axis_tuser,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // [6:0] function_code, [54:7] chunk_block, [60:55] chunk_count,
    // [70:61] cylinder, [78:71] head, [84:79] sector, [100:85] packed_cx,
    // [116:101] packed_dx, [119:117] zero
    output logic [dcs_pkg::M_DATA_W-1:0]           m_axis_tdata,
    // [0] range_error
    output logic                                   m_axis_tuser,
    output logic                                   m_axis_tlast,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [dcs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [dcs_pkg::CFG_DATA_W-1:0]    cfg_data
);

    dcs_pkg::cmd_t  cmd;
    dcs_pkg::stat_t stat;

    assign cfg_ready = 1'b1;

    dcs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_axis_tvalid),
        .s_ready (s_axis_tready),
        .m_valid (m_axis_tvalid),
        .m_ready (m_axis_tready),
        .stat    (stat),
        .cmd     (cmd)
    );

    dcs_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .s_data    (s_axis_tdata),
        .s_user    (s_axis_tuser),
        .cfg_we    (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_data    (m_axis_tdata),
        .m_user    (m_axis_tuser),
        .m_last    (m_axis_tlast)
    );

endmodule

`default_nettype wire

>>> bench/chs_command_checker.sv
// Watches the request, command and register channels, predicts the disk
// commands of every accepted request and compares them in order.
module chs_command_checker
    import dcs_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_axis_tvalid,
    input  wire logic                  s_axis_tready,
    input  wire logic [S_DATA_W-1:0]   s_axis_tdata,
    input  wire logic                  s_axis_tuser,
    input  wire logic                  m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    input  wire logic [M_DATA_W-1:0]   m_axis_tdata,
    input  wire logic                  m_axis_tuser,
    input  wire logic                  m_axis_tlast,
    input  wire logic                  cfg_valid,
    input  wire logic                  cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output int                         fail_count,
    output int                         commands_left,
    output int                         commands_checked,
    output int                         range_errors
);

    // m_axis_tdata layout, top bits first
    typedef struct packed {
        logic [2:0]  pad;
        logic [15:0] dx;
        logic [15:0] cx;
        logic [5:0]  sector;
        logic [7:0]  head;
        logic [9:0]  cyl;
        logic [5:0]  count;
        logic [47:0] block;
        logic [6:0]  fn;
    } cmd_image_t;

    typedef struct packed {
        cmd_image_t img;
        logic       err;
        logic       last;
    } disk_cmd_t;

    disk_cmd_t  pending_cmds[$];

    logic [5:0] geo_spt;
    logic [8:0] geo_heads;
    logic [7:0] drive;
    logic       ext_mode;
    logic [4:0] chunk_max;

    initial begin
        fail_count       = 0;
        commands_left    = 0;
        commands_checked = 0;
        range_errors     = 0;
    end

    function automatic void split_request(logic wr, logic [47:0] start, logic [6:0] blocks);
        logic [63:0] blk, resid, spt, hds, bpc, x, cyl, off, hd, sec;
        disk_cmd_t   c;
        blk   = 64'(start);
        resid = 64'(blocks);
        spt   = (geo_spt == 0) ? 64'd1 : 64'(geo_spt);
        hds   = (geo_heads == 0) ? 64'd1 : 64'(geo_heads);
        bpc   = spt * hds;
        if (resid > 64'(MAX_BLOCKS))
            resid = 64'(MAX_BLOCKS);
        while (resid > 0) begin
            x = spt - (blk % spt);
            if (x > resid)
                x = resid;
            if (chunk_max != 0 && x > 64'(chunk_max))
                x = 64'(chunk_max);
            c            = '0;
            c.last       = (x == resid);
            c.img.block  = blk[47:0];
            c.img.count  = x[5:0];
            if (ext_mode) begin
                c.img.fn = wr ? FN_EXT_WRITE : FN_EXT_READ;
                c.img.dx = {8'h00, drive};
            end else begin
                cyl          = blk / bpc;
                off          = blk % bpc;
                hd           = off / spt;
                sec          = off % spt + 1;
                c.img.fn     = wr ? FN_WRITE : FN_READ;
                c.img.head   = hd[7:0];
                c.img.sector = sec[5:0];
                if (cyl > 64'(MAX_CYLINDER)) begin
                    // out of reach: one error command ends the request
                    c.err  = 1'b1;
                    c.last = 1'b1;
                    pending_cmds.push_back(c);
                    break;
                end
                c.img.cyl = cyl[9:0];
                c.img.cx  = {cyl[7:0], cyl[9:8], sec[5:0]};
                c.img.dx  = {hd[7:0], drive};
            end
            pending_cmds.push_back(c);
            blk   = (blk + x) & 64'hFFFF_FFFF_FFFF;
            resid = resid - x;
        end
    endfunction

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge aclk) begin
        cmd_image_t got;
        disk_cmd_t  want;
        if (!aresetn) begin
            geo_spt   = 6'd63;
            geo_heads = 9'd16;
            drive     = 8'd128;
            ext_mode  = 1'b0;
            chunk_max = 5'd0;
            pending_cmds.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_SPT:   geo_spt   = cfg_data[5:0];
                    REG_HEADS: geo_heads = cfg_data[8:0];
                    REG_DRIVE: drive     = cfg_data[7:0];
                    REG_EXT:   ext_mode  = cfg_data[0];
                    REG_LIMIT: chunk_max = cfg_data[4:0];
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                split_request(s_axis_tuser, s_axis_tdata[47:0], s_axis_tdata[54:48]);
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata;
                if (pending_cmds.size() == 0) begin
                    $error("command %0h with no request outstanding", m_axis_tdata);
                    fail_count++;
                end else begin
                    want = pending_cmds.pop_front();
                    check_field("function_code", 64'(want.img.fn), 64'(got.fn));
                    check_field("chunk_block", 64'(want.img.block), 64'(got.block));
                    check_field("chunk_count", 64'(want.img.count), 64'(got.count));
                    check_field("cylinder", 64'(want.img.cyl), 64'(got.cyl));
                    check_field("head", 64'(want.img.head), 64'(got.head));
                    check_field("sector", 64'(want.img.sector), 64'(got.sector));
                    check_field("packed_cx", 64'(want.img.cx), 64'(got.cx));
                    check_field("packed_dx", 64'(want.img.dx), 64'(got.dx));
                    check_field("range_error", 64'(want.err), 64'(m_axis_tuser));
                    check_field("last", 64'(want.last), 64'(m_axis_tlast));
                    commands_checked++;
                    if (want.err)
                        range_errors++;
                end
            end
        end
        commands_left = pending_cmds.size();
    end

endmodule

>>> bench/disk_request_chs_splitter_test.sv
module disk_request_chs_splitter_test;
    import dcs_pkg::*;

    localparam int STALL_LIMIT  = 2000;
    localparam int SETTLE_TICKS = 150;

    logic                  aclk;
    logic                  aresetn       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [S_DATA_W-1:0]   s_axis_tdata  = '0;
    logic                  s_axis_tuser  = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_axis_tdata;
    logic                  m_axis_tuser;
    logic                  m_axis_tlast;
    logic                  cfg_valid     = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index     = '0;
    logic [CFG_DATA_W-1:0] cfg_data      = '0;

    int fail_count, commands_left, commands_checked, range_errors;
    int tx_idle_pct = 6;
    int rx_idle_pct = 66;
    int requests_sent = 0;
    int settings_used = 1;
    int stall_cycles  = 0;

    // stimulus-side copy of the geometry, used to aim requests
    int cur_spt   = 63;
    int cur_heads = 16;
    int cur_ext   = 0;

    disk_request_chs_splitter dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    chs_command_checker u_checker (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_axis_tvalid    (s_axis_tvalid),
        .s_axis_tready    (s_axis_tready),
        .s_axis_tdata     (s_axis_tdata),
        .s_axis_tuser     (s_axis_tuser),
        .m_axis_tvalid    (m_axis_tvalid),
        .m_axis_tready    (m_axis_tready),
        .m_axis_tdata     (m_axis_tdata),
        .m_axis_tuser     (m_axis_tuser),
        .m_axis_tlast     (m_axis_tlast),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .fail_count       (fail_count),
        .commands_left    (commands_left),
        .commands_checked (commands_checked),
        .range_errors     (range_errors)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    always @(posedge aclk)
        m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);

    always @(posedge aclk) begin
        if (!aresetn || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (cfg_valid && cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("watchdog: no item moved for %0d cycles", stall_cycles);
            $display("== FAIL ==");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic send_request(int wr, logic [47:0] start, logic [6:0] blocks);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, blocks, start};
        s_axis_tuser  <= wr[0];
        @(posedge aclk);
        while (!s_axis_tready)
            @(posedge aclk);
        requests_sent++;
    endtask

    // hold requests back until every command is out and the block is idle
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (commands_left != 0)
            @(posedge aclk);
        repeat (SETTLE_TICKS) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[CFG_DATA_W-1:0];
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
    endtask

    task automatic configure(int spt, int heads, int unit, int ext, int limit);
        settle();
        write_reg(REG_SPT, spt);
        write_reg(REG_HEADS, heads);
        write_reg(REG_DRIVE, unit);
        write_reg(REG_EXT, ext);
        write_reg(REG_LIMIT, limit);
        cfg_valid <= 1'b0;
        cur_spt   = spt;
        cur_heads = heads;
        cur_ext   = ext;
        settings_used++;
    endtask

    task automatic shuffle_settings();
        int spt, heads, unit, limit;
        case ($urandom_range(3))
            0:       spt = 0;
            1:       spt = 1;
            2:       spt = 63;
            default: spt = $urandom_range(62, 2);
        endcase
        case ($urandom_range(6))
            0:       heads = 0;
            1:       heads = 1;
            2:       heads = 255;
            3:       heads = 256;
            4:       heads = 511;
            default: heads = $urandom_range(254, 2);
        endcase
        case ($urandom_range(3))
            0:       limit = 0;
            1:       limit = 18;
            2:       limit = 31;
            default: limit = $urandom_range(17, 1);
        endcase
        unit = $urandom_range(255);
        configure(spt, heads, unit, ($urandom_range(9) < 4) ? 1 : 0, limit);
    endtask

    task automatic random_request();
        int unsigned spt_eff, bpc, cap, pick;
        logic [47:0] start;
        logic [6:0]  blocks;
        spt_eff = (cur_spt == 0) ? 1 : cur_spt;
        bpc     = spt_eff * ((cur_heads == 0) ? 1 : cur_heads);
        cap     = 1024 * bpc;
        pick    = $urandom_range(99);
        if (cur_ext == 0) begin
            // mostly addresses the geometry can reach, some straddling the last cylinder
            if (pick < 60)
                start = 48'($urandom_range(cap - 1));
            else if (pick < 75)
                start = 48'(cap - 1 - $urandom_range(3 * spt_eff));
            else if (pick < 87)
                start = 48'($urandom_range(cap / spt_eff - 1, 1) * spt_eff - $urandom_range(2));
            else
                start = 48'({$urandom, $urandom});
        end else begin
            if (pick < 40)
                start = 48'({$urandom, $urandom});
            else if (pick < 65)
                start = 48'hFFFF_FFFF_FFFF - 48'($urandom_range(80));
            else
                start = 48'($urandom);
        end
        pick = $urandom_range(99);
        if (pick < 4)
            blocks = 7'd0;
        else if (pick < 14)
            blocks = 7'($urandom_range(127, 65));
        else if (pick < 28)
            blocks = 7'd64;
        else
            blocks = 7'($urandom_range(63, 1));
        send_request($urandom_range(1), start, blocks);
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // reset geometry: 63 sectors, 16 heads, CHS, no chunk limit
        send_request(0, 48'd0, 7'd1);
        send_request(1, 48'd62, 7'd3);
        send_request(0, 48'd0, 7'd0);
        send_request(1, 48'd1000, 7'd64);
        send_request(0, 48'd5, 7'd127);
        send_request(0, 48'(1024 * 1008 - 2), 7'd10);
        send_request(1, 48'hFFFF_FFFF_FFFF, 7'd5);

        configure(1, 256, 255, 0, 18);
        send_request(0, 48'd300, 7'd20);
        // zero geometry acts as one sector, one head
        configure(0, 0, 0, 0, 31);
        send_request(1, 48'd1020, 7'd8);
        // head numbers past one byte
        configure(63, 511, 90, 0, 0);
        send_request(1, 48'(63 * 300 + 5), 7'd64);
        send_request(0, 48'(63 * 511 * 1023 + 63 * 510), 7'd64);

        configure(63, 16, 128, 1, 0);
        send_request(0, 48'hFFFF_FFFF_FFF0, 7'd64);
        send_request(1, 48'd0, 7'd64);
        send_request(1, 48'd12345, 7'd0);
        configure(63, 16, 200, 1, 18);
        send_request(0, 48'h8000_0000_0001, 7'd64);
        send_request(1, 48'hFFFF_FFFF_FFFF, 7'd1);
        configure(1, 1, 7, 1, 31);
        send_request(0, 48'd10, 7'd40);

        for (int seg = 0; seg < 13; seg++) begin
            if (seg == 5) begin
                tx_idle_pct = 66;
                rx_idle_pct = 6;
            end else if (seg == 9) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            shuffle_settings();
            repeat (30) random_request();
        end

        settle();
        $display("Run covered %0d requests over %0d register settings,", requests_sent,
                 settings_used);
        $display("%0d disk commands compared, %0d of them cylinder range errors.",
                 commands_checked, range_errors);
        if (fail_count == 0 && commands_left == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
